// ===== rtl/detour_ratio_lot_filter_defines.svh =====
// assertion macros for the lot filter
`ifndef DETOUR_RATIO_LOT_FILTER_DEFINES_SVH
`define DETOUR_RATIO_LOT_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// condition must never hold
`define DRLF_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("drlf assertion failed");
// consequent must hold in the cycle after the antecedent
`define DRLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drlf assertion failed");
`else
`define DRLF_ASSERT_NEVER(lbl, cond)
`define DRLF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/drlf_pkg.sv =====
package drlf_pkg;

    localparam int COORD_BITS     = 24;
    localparam int IDX_BITS       = 16;
    localparam int DIST_BITS      = 25;
    localparam int PCT_BITS       = 7;
    localparam int SQ_BITS        = 52;
    localparam int ROOT_BITS      = SQ_BITS / 2;
    localparam int TOTAL_BITS     = ROOT_BITS + 1;
    localparam int NUM_BITS       = 32;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEST_X   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEST_Y   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PCT  = 3'd4;

    localparam logic [1:0] REASON_KEEP  = 2'd0;
    localparam logic [1:0] REASON_ZERO  = 2'd1;
    localparam logic [1:0] REASON_FAR   = 2'd2;
    localparam logic [1:0] REASON_SHARE = 2'd3;

    localparam logic [PCT_BITS-1:0] PCT_RESET   = 7'd100;
    localparam logic [NUM_BITS-1:0] PCT_SCALE   = 32'd100;

    typedef struct packed {
        logic [COORD_BITS-1:0] lot_x;
        logic [COORD_BITS-1:0] lot_y;
        logic [IDX_BITS-1:0]   lot_index;
    } drlf_in_t;

    typedef struct packed {
        logic                  keep;
        logic [1:0]            reject_reason;
        logic [IDX_BITS-1:0]   lot_index_out;
        logic [DIST_BITS-1:0]  dist_to_origin;
        logic [DIST_BITS-1:0]  dist_to_dest;
        logic [PCT_BITS-1:0]   origin_share_pct;
    } drlf_out_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] origin_x;
        logic [COORD_BITS-1:0] origin_y;
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
        logic [PCT_BITS-1:0]   max_pct;
    } drlf_cfg_t;

    typedef struct packed {
        logic [SQ_BITS-1:0]  sq_o;
        logic [SQ_BITS-1:0]  sq_d;
        logic [SQ_BITS-1:0]  sq_l;
        logic [IDX_BITS-1:0] idx;
    } drlf_work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } drlf_qstat_t;

endpackage

// ===== rtl/drlf_front.sv =====
module drlf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  drlf_pkg::drlf_in_t  in_data,
    input  drlf_pkg::drlf_cfg_t cfg,
    input  drlf_pkg::drlf_qstat_t qstat,
    output logic                push,
    output drlf_pkg::drlf_work_t work
);
    import drlf_pkg::*;

    logic                  s1_v_reg;
    logic [COORD_BITS-1:0] dox_reg, doy_reg, ddx_reg, ddy_reg, odx_reg, ody_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic                  s2_v_reg;
    drlf_work_t            work_reg;
    drlf_work_t            work_next;
    logic                  adv;
    logic [2*COORD_BITS-1:0] p_ox, p_oy, p_dx, p_dy, p_lx, p_ly;

    function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    assign adv      = !s2_v_reg || !qstat.full;
    assign in_ready = !s1_v_reg || adv;
    assign push     = s2_v_reg && !qstat.full;
    assign work     = work_reg;

    // squares of the coordinate differences
    always_comb
    begin
        p_ox = dox_reg * dox_reg;
        p_oy = doy_reg * doy_reg;
        p_dx = ddx_reg * ddx_reg;
        p_dy = ddy_reg * ddy_reg;
        p_lx = odx_reg * odx_reg;
        p_ly = ody_reg * ody_reg;
        work_next.sq_o = SQ_BITS'(p_ox) + SQ_BITS'(p_oy);
        work_next.sq_d = SQ_BITS'(p_dx) + SQ_BITS'(p_dy);
        // four times the trip length squared, so its root is twice the length
        work_next.sq_l = (SQ_BITS'(p_lx) + SQ_BITS'(p_ly)) << 2;
        work_next.idx  = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_v_reg <= in_valid;
            if (adv)
                s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            dox_reg <= absdiff(cfg.origin_x, in_data.lot_x);
            doy_reg <= absdiff(cfg.origin_y, in_data.lot_y);
            ddx_reg <= absdiff(cfg.dest_x, in_data.lot_x);
            ddy_reg <= absdiff(cfg.dest_y, in_data.lot_y);
            odx_reg <= absdiff(cfg.origin_x, cfg.dest_x);
            ody_reg <= absdiff(cfg.origin_y, cfg.dest_y);
            idx_reg <= in_data.lot_index;
        end
        if (adv)
            work_reg <= work_next;
    end

endmodule

// ===== rtl/drlf_queue.sv =====
`include "detour_ratio_lot_filter_defines.svh"

module drlf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  drlf_pkg::drlf_work_t  wr_data,
    input  logic                  pop,
    output drlf_pkg::drlf_work_t  head,
    output drlf_pkg::drlf_qstat_t qstat
);
    import drlf_pkg::*;

    drlf_work_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    `DRLF_ASSERT_NEVER(a_no_overflow, push && qstat.full)
    `DRLF_ASSERT_NEVER(a_no_underflow, pop && qstat.empty)
    `DRLF_ASSERT_NEVER(a_count_range, count_reg > QUEUE_CNT_BITS'(QUEUE_DEPTH))
    `DRLF_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== rtl/drlf_sqrt.sv =====
module drlf_sqrt #(
    parameter int VW = 52
) (
    input  logic              clk,
    input  logic              en,
    input  logic [VW-1:0]     v,
    output logic [VW/2-1:0]   root,
    output logic [VW/2+1:0]   rem
);
    localparam int RW = VW / 2;

    logic [VW-1:0] val_reg  [RW];
    logic [RW+1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];

    // one root bit per stage, restoring digit recurrence
    for (genvar g = 0; g < RW; g++)
    begin : g_stage
        logic [VW-1:0] val_in;
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;

        if (g == 0)
        begin : g_first
            assign val_in  = v;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign val_in  = val_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        assign rem_sh = {rem_in[RW-1:0], val_in[VW-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[g] <= val_in << 2;
                if (rem_sh >= trial)
                begin
                    rem_reg[g]  <= rem_sh - trial;
                    root_reg[g] <= {root_in[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g]  <= rem_sh;
                    root_reg[g] <= {root_in[RW-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[RW-1];
    assign rem  = rem_reg[RW-1];

endmodule

// ===== rtl/drlf_div.sv =====
module drlf_div #(
    parameter int NW = 32,
    parameter int DW = 27,
    parameter int QW = 7
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);
    localparam int SW = NW + QW;

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    // one quotient bit per stage, most significant first
    for (genvar g = 0; g < QW; g++)
    begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] dsh;

        if (g == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        assign dsh = SW'(den_in) << (QW - 1 - g);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[g] <= den_in;
                if (SW'(rem_in) >= dsh)
                begin
                    rem_reg[g] <= rem_in - dsh[NW-1:0];
                    quo_reg[g] <= {quo_in[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g] <= rem_in;
                    quo_reg[g] <= {quo_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ===== rtl/drlf_back.sv =====
module drlf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  drlf_pkg::drlf_work_t  head,
    input  drlf_pkg::drlf_qstat_t qstat,
    output logic                  pop,
    input  logic [drlf_pkg::PCT_BITS-1:0] max_pct,
    output logic                  out_valid,
    input  logic                  out_ready,
    output drlf_pkg::drlf_out_t   out_data
);
    import drlf_pkg::*;

    localparam int SQ_LAT = ROOT_BITS;
    localparam int LAT    = SQ_LAT + 1 + PCT_BITS;

    logic                  adv;
    logic [LAT-1:0]        vld_reg;
    logic [IDX_BITS-1:0]   idx_reg [LAT];

    logic [ROOT_BITS-1:0]  r_o, r_d, r_l;
    logic [ROOT_BITS+1:0]  m_o, m_d, m_l;
    logic [ROOT_BITS-1:0]  d1_reg, d2_reg, lim_reg;
    logic [ROOT_BITS-1:0]  d1_pipe_reg [PCT_BITS];
    logic [ROOT_BITS-1:0]  d2_pipe_reg [PCT_BITS];
    logic [ROOT_BITS-1:0]  lim_pipe_reg [PCT_BITS];
    logic [TOTAL_BITS-1:0] total;
    logic [NUM_BITS-1:0]   num;
    logic [PCT_BITS-1:0]   quo;
    logic [TOTAL_BITS-1:0] tot_last;
    logic [PCT_BITS-1:0]   share;
    logic [1:0]            reason;
    logic                  out_v_reg;
    drlf_out_t             out_reg, out_next;

    assign adv = !out_v_reg || out_ready;
    assign pop = adv && !qstat.empty;

    drlf_sqrt #(.VW(SQ_BITS)) u_sqrt_o (.clk(clk), .en(adv), .v(head.sq_o), .root(r_o), .rem(m_o));
    drlf_sqrt #(.VW(SQ_BITS)) u_sqrt_d (.clk(clk), .en(adv), .v(head.sq_d), .root(r_d), .rem(m_d));
    drlf_sqrt #(.VW(SQ_BITS)) u_sqrt_l (.clk(clk), .en(adv), .v(head.sq_l), .root(r_l), .rem(m_l));

    // rounding: a remainder above the root means the true root is past the half
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg  <= r_o + ROOT_BITS'(m_o > {2'b00, r_o});
            d2_reg  <= r_d + ROOT_BITS'(m_d > {2'b00, r_d});
            lim_reg <= r_l + ROOT_BITS'(m_l > {2'b00, r_l});
        end
    end

    assign total = TOTAL_BITS'(d1_reg) + TOTAL_BITS'(d2_reg);
    assign num   = NUM_BITS'(d1_reg) * PCT_SCALE;

    drlf_div #(.NW(NUM_BITS), .DW(TOTAL_BITS), .QW(PCT_BITS)) u_div (
        .clk(clk), .en(adv), .num(num), .den(total), .quo(quo)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg[0] <= head.idx;
            for (int i = 1; i < LAT; i++)
                idx_reg[i] <= idx_reg[i-1];
            d1_pipe_reg[0]  <= d1_reg;
            d2_pipe_reg[0]  <= d2_reg;
            lim_pipe_reg[0] <= lim_reg;
            for (int i = 1; i < PCT_BITS; i++)
            begin
                d1_pipe_reg[i]  <= d1_pipe_reg[i-1];
                d2_pipe_reg[i]  <= d2_pipe_reg[i-1];
                lim_pipe_reg[i] <= lim_pipe_reg[i-1];
            end
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        tot_last = TOTAL_BITS'(d1_pipe_reg[PCT_BITS-1]) + TOTAL_BITS'(d2_pipe_reg[PCT_BITS-1]);
        share    = (tot_last == '0) ? '0 : quo;
        priority if (tot_last == '0)
            reason = REASON_ZERO;
        else if (tot_last > TOTAL_BITS'(lim_pipe_reg[PCT_BITS-1]))
            reason = REASON_FAR;
        else if (share > max_pct)
            reason = REASON_SHARE;
        else
            reason = REASON_KEEP;
        out_next.keep             = (reason == REASON_KEEP);
        out_next.reject_reason    = reason;
        out_next.lot_index_out    = idx_reg[LAT-1];
        out_next.dist_to_origin   = d1_pipe_reg[PCT_BITS-1][DIST_BITS-1:0];
        out_next.dist_to_dest     = d2_pipe_reg[PCT_BITS-1][DIST_BITS-1:0];
        out_next.origin_share_pct = share;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg   <= {vld_reg[LAT-2:0], pop};
            out_v_reg <= vld_reg[LAT-1];
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/detour_ratio_lot_filter.sv =====
// park-and-ride lot screen: each request carries one lot's coordinates and record
// index, and yields exactly one result with the rounded distances from the trip
// origin and to the trip destination, the origin share in percent, a keep flag and
// a reject reason (zero total, longer than twice the trip, share too high, in that
// order). one request is taken every clock cycle when the output side keeps up; a
// result passes the difference registers that load at acceptance, the squares
// register in the front, a queue slot, the bit-per-stage square root pipes, the
// rounding register, the bit-per-stage share divider and the output register. the
// front and the back are decoupled by a four-entry queue, which lets new requests
// enter while a result still waits. trip coordinates and the share limit are
// written through the cfg port; the user must write them only while the block is
// idle, since the block itself does not enforce it. the limit resets to 100
// percent and the coordinates to zero.
module detour_ratio_lot_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  drlf_pkg::drlf_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output drlf_pkg::drlf_out_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [drlf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [drlf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import drlf_pkg::*;

    // configuration registers
    drlf_cfg_t   cfg_reg;

    // front to queue to back
    logic        push;
    logic        pop;
    drlf_work_t  work;
    drlf_work_t  head;
    drlf_qstat_t qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.dest_x   <= '0;
            cfg_reg.dest_y   <= '0;
            cfg_reg.max_pct  <= PCT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: cfg_reg.origin_x <= cfg_data[COORD_BITS-1:0];
                REG_ORIGIN_Y: cfg_reg.origin_y <= cfg_data[COORD_BITS-1:0];
                REG_DEST_X:   cfg_reg.dest_x   <= cfg_data[COORD_BITS-1:0];
                REG_DEST_Y:   cfg_reg.dest_y   <= cfg_data[COORD_BITS-1:0];
                REG_MAX_PCT:  cfg_reg.max_pct  <= cfg_data[PCT_BITS-1:0];
                // writes to unused indexes are dropped
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // front: coordinate differences and squared distances
    drlf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .push     (push),
        .work     (work)
    );

    // short queue so front and back stall independently
    drlf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (work),
        .pop     (pop),
        .head    (head),
        .qstat   (qstat)
    );

    // back: roots, rounding, share division, screening and output register
    drlf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .max_pct   (cfg_reg.max_pct),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
